// ===== hw/rtl/pctc_pkg.sv =====
`default_nettype none
package pctc_pkg;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int ACC_W  = 32;
  localparam int KIND_W = 2;

  localparam int QUEUE_DEPTH = 2;

  // stream payload layout
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CODE   = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENCODE,
    ST_SCAN
  } state_t;

  // request after classification
  typedef struct packed {
    op_t               op;
    logic              sym_ok;
    logic              load_ok;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic              bit_val;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [CODE_W-1:0] code;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/pctc_front.sv =====
`default_nettype none
module pctc_front
  import pctc_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [KIND_W-1:0]    req_type,
  input  wire logic [SYM_W-1:0]     symbol_in,
  input  wire logic [CODE_W-1:0]    entry_code,
  input  wire logic [LEN_W-1:0]     entry_length,
  input  wire logic                 bit_in,
  output logic                      q_valid,
  output cmd_t                      q_cmd,
  input  wire logic                 q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              cmd_in;
  logic [CODE_W:0]   len_mask;
  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;

  // code bits above the length are dropped here
  assign len_mask = ((CODE_W+1)'(1) << entry_length) - (CODE_W+1)'(1);

  always_comb begin
    cmd_in.op      = op_t'(req_type);
    cmd_in.sym_ok  = ({1'b0, symbol_in} < (SYM_W+1)'(SYMBOL_COUNT));
    cmd_in.load_ok = cmd_in.sym_ok && (entry_length <= LEN_W'(CODE_W));
    cmd_in.symbol  = symbol_in;
    cmd_in.code    = entry_code & len_mask[CODE_W-1:0];
    cmd_in.length  = entry_length;
    cmd_in.bit_val = bit_in;
  end

  assign s_tready = (count < QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_cmd    = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pctc_back.sv =====
`default_nettype none
module pctc_back
  import pctc_pkg::*;
#(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire cmd_t                 q_cmd,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output kind_t                     result_kind,
  output logic [CODE_W-1:0]         code_out,
  output logic [LEN_W-1:0]          code_length_out,
  output logic [SYM_W-1:0]          symbol_out
);

  localparam int IDX_W     = $clog2(SYMBOL_COUNT);
  localparam int LEN_LIMIT = (MAX_CODE_LEN < ACC_W) ? MAX_CODE_LEN : ACC_W;

  entry_t                  table_mem [SYMBOL_COUNT];
  entry_t                  rd_data;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;

  logic [SYMBOL_COUNT-1:0] valid_bits;
  logic [SYMBOL_COUNT-1:0] valid_bits_next;

  state_t                  state;
  state_t                  state_next;
  logic [IDX_W-1:0]        scan_idx;
  logic [IDX_W-1:0]        scan_idx_next;
  logic [ACC_W-1:0]        acc_bits;
  logic [ACC_W-1:0]        acc_bits_next;
  logic [LEN_W-1:0]        acc_len;
  logic [LEN_W-1:0]        acc_len_next;
  logic                    enc_hit;
  logic                    enc_hit_next;

  logic [IDX_W-1:0]        q_idx;
  logic                    scan_hit;
  logic                    out_free;

  logic                    emit;
  kind_t                   emit_kind;
  logic [CODE_W-1:0]       emit_code;
  logic [LEN_W-1:0]        emit_len;
  logic [SYM_W-1:0]        emit_sym;

  assign q_idx    = q_cmd.symbol[IDX_W-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign scan_hit = valid_bits[scan_idx] && (rd_data.length == acc_len) &&
                    (rd_data.code == acc_bits);

  always_comb begin
    state_next      = state;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = scan_idx;
    wr_en           = 1'b0;
    valid_bits_next = valid_bits;
    scan_idx_next   = scan_idx;
    acc_bits_next   = acc_bits;
    acc_len_next    = acc_len;
    enc_hit_next    = enc_hit;
    emit            = 1'b0;
    emit_kind       = KIND_CODE;
    emit_code       = '0;
    emit_len        = '0;
    emit_sym        = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_CLEAR: begin
              valid_bits_next = '0;
              acc_bits_next   = '0;
              acc_len_next    = '0;
            end
            OP_LOAD: begin
              // a symbol that already has an entry keeps it
              if (q_cmd.load_ok && !valid_bits[q_idx]) begin
                wr_en                  = 1'b1;
                valid_bits_next[q_idx] = 1'b1;
              end
            end
            OP_ENCODE: begin
              rd_en        = 1'b1;
              rd_addr      = q_idx;
              enc_hit_next = q_cmd.sym_ok && valid_bits[q_idx];
              state_next   = ST_ENCODE;
            end
            OP_DECODE: begin
              acc_bits_next = {acc_bits[ACC_W-2:0], q_cmd.bit_val};
              acc_len_next  = acc_len + 1'b1;
              rd_en         = 1'b1;
              rd_addr       = '0;
              scan_idx_next = '0;
              state_next    = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ENCODE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_CODE;
          emit_code  = enc_hit ? rd_data.code : '0;
          emit_len   = enc_hit ? rd_data.length : '0;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // lowest matching symbol wins since the scan runs upward
        if (scan_hit) begin
          if (out_free) begin
            emit          = 1'b1;
            emit_kind     = KIND_SYMBOL;
            emit_sym      = SYM_W'(scan_idx);
            acc_bits_next = '0;
            acc_len_next  = '0;
            state_next    = ST_IDLE;
          end
        end else if (scan_idx == IDX_W'(SYMBOL_COUNT - 1)) begin
          if (acc_len >= LEN_W'(LEN_LIMIT)) begin
            if (out_free) begin
              emit          = 1'b1;
              emit_kind     = KIND_ERROR;
              acc_bits_next = '0;
              acc_len_next  = '0;
              state_next    = ST_IDLE;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          rd_en         = 1'b1;
          rd_addr       = scan_idx + 1'b1;
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[q_idx] <= '{length: q_cmd.length, code: q_cmd.code};
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_idx   <= '0;
      acc_bits   <= '0;
      acc_len    <= '0;
      enc_hit    <= 1'b0;
      valid_bits <= '0;
    end else begin
      state      <= state_next;
      scan_idx   <= scan_idx_next;
      acc_bits   <= acc_bits_next;
      acc_len    <= acc_len_next;
      enc_hit    <= enc_hit_next;
      valid_bits <= valid_bits_next;
    end
  end

  // result register parts the scan from the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind     <= emit_kind;
      code_out        <= emit_code;
      code_length_out <= emit_len;
      symbol_out      <= emit_sym;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/prefix_code_table_codec.sv =====
// prefix code table codec: a table of byte symbols with prefix codes, used to
// encode symbols and to decode a coded bit stream one bit per request.
// input stream (s_*): tuser carries the request kind (clear, load, encode,
// decode bit); tdata carries the symbol, code, length and coded bit.
// output stream (m_*): tuser carries the result kind (code, symbol, error);
// tdata carries the code, its length and the decoded symbol.
// clear and load give no result; encode gives one; a decode bit gives one on
// a table hit or when the pending code reaches its length limit.
// a two-entry request queue sits between the intake and the table engine,
// so requests are taken while the engine works or a result waits.
// clear and load act in the idle state; encode reads the table entry and then
// emits; a decode bit scans the table memory one entry per cycle from
// symbol 0 upward; the scan stops at the first hit.
// reset empties the table at once through per-entry valid flags and clears
// the pending code; no memory sweep follows.
// when the receiver stalls, the result stays in the output register, the
// engine holds its next result, and the queue fills and s_tready drops.
`default_nettype none
module prefix_code_table_codec
  import pctc_pkg::*;
#(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // symbol_in[7:0], entry_code[39:8], entry_length[45:40], bit_in[46], zero[47]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[1:0]
  input  wire logic [KIND_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // code_out[31:0], code_length_out[37:32], symbol_out[45:38], zero[47:46]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  // result_kind[1:0]
  output logic [KIND_W-1:0]          m_tuser
);

  localparam int SYM_LO  = 0;
  localparam int CODE_LO = SYM_LO + SYM_W;
  localparam int LEN_LO  = CODE_LO + CODE_W;
  localparam int BIT_LO  = LEN_LO + LEN_W;
  localparam int OUT_USED = CODE_W + LEN_W + SYM_W;

  logic              q_valid;
  cmd_t              q_cmd;
  logic              q_pop;
  kind_t             result_kind;
  logic [CODE_W-1:0] code_out;
  logic [LEN_W-1:0]  code_length_out;
  logic [SYM_W-1:0]  symbol_out;

  pctc_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .req_type     (s_tuser),
    .symbol_in    (s_tdata[SYM_LO +: SYM_W]),
    .entry_code   (s_tdata[CODE_LO +: CODE_W]),
    .entry_length (s_tdata[LEN_LO +: LEN_W]),
    .bit_in       (s_tdata[BIT_LO]),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop)
  );

  pctc_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .result_kind     (result_kind),
    .code_out        (code_out),
    .code_length_out (code_length_out),
    .symbol_out      (symbol_out)
  );

  assign m_tdata = {(OUT_DATA_W - OUT_USED)'(0), symbol_out, code_length_out, code_out};
  assign m_tuser = result_kind;

endmodule
`default_nettype wire

// ===== hw/rtl/pctc_checker.sv =====
`default_nettype none
module pctc_checker
  import pctc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [KIND_W-1:0]     m_tuser
);

  // a result held back by the receiver stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // nothing comes out in the cycle after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");

  // symbol and error results carry no code
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_CODE) |-> (m_tdata[CODE_W+LEN_W-1:0] == '0))
    else $error("code bits on a decode result");

  // encode results carry no symbol and a length of at most the code width
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_CODE) |->
      (m_tdata[CODE_W+LEN_W +: SYM_W] == '0) &&
      (m_tdata[CODE_W +: LEN_W] <= LEN_W'(CODE_W)))
    else $error("malformed encode result");

endmodule

bind prefix_code_table_codec pctc_checker u_pctc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
